// ===== rtl/dual_deque_with_member_search_assert.svh =====
// Assertion macros shared by the block's RTL.
// Both sample on the rising edge of i_clk and stay quiet while i_rst_n is low.
`ifndef DUAL_DEQUE_WITH_MEMBER_SEARCH_ASSERT_SVH
`define DUAL_DEQUE_WITH_MEMBER_SEARCH_ASSERT_SVH

// Condition that must hold in the same cycle as the trigger.
`define DDS_ASSERT_SAME(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |-> (cond)) \
        else $error(msg);

// Condition that must hold in the cycle after the trigger.
`define DDS_ASSERT_NEXT(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

// ===== rtl/dds_pkg.sv =====
package dds_pkg;

    typedef enum logic [1:0] {
        OP_APPEND    = 2'd0,
        OP_POP_FRONT = 2'd1,
        OP_POP_BACK  = 2'd2,
        OP_SEARCH    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_POP,
        S_SCAN,
        S_DONE
    } t_state;

    localparam int NAME_HEAD_W = 64;
    localparam int NAME_TAIL_W = 8;
    localparam int NAME_W      = NAME_HEAD_W + NAME_TAIL_W;

    // Pointer updates for the selected list, applied by the top level.
    typedef struct packed {
        logic inc_front;
        logic inc_count;
        logic dec_count;
    } t_ptr_cmd;

    typedef struct packed {
        t_status                  status;
        logic                     found;
        logic [NAME_HEAD_W-1:0]   head;
        logic [NAME_TAIL_W-1:0]   tail;
    } t_result;

endpackage

// ===== rtl/dds_ram.sv =====
module dds_ram import dds_pkg::*; #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/dds_ctrl.sv =====
module dds_ctrl import dds_pkg::*; #(
    parameter int LIST_DEPTH = 16,
    localparam int PW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1,
    localparam int CW = $clog2(LIST_DEPTH + 1)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_accept,
    input  t_op                    i_op,
    input  logic [NAME_HEAD_W-1:0] i_head,
    input  logic [NAME_TAIL_W-1:0] i_tail,
    input  logic [PW-1:0]          i_front,
    input  logic [CW-1:0]          i_count,
    input  logic                   i_out_free,
    input  logic [NAME_W-1:0]      i_rdata,
    output logic                   o_busy,
    output logic                   o_we,
    output logic                   o_re,
    output logic [PW-1:0]          o_slot,
    output t_ptr_cmd               o_ptr,
    output logic                   o_load,
    output t_result                o_result
);

    localparam int SW = CW + 1;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_k, n_k;
    logic [PW-1:0]   r_ring, n_ring;
    t_result         r_result, n_result;

    logic [SW-1:0]   w_sum;
    logic [PW-1:0]   w_end_slot;
    logic [PW-1:0]   w_front_next;
    logic [PW-1:0]   w_ring_next;
    logic            w_hit;
    logic            w_full;
    logic            w_empty;
    logic            w_last;

    // Ring slot at offset count (append) or count-1 (pop back): the sum stays
    // below twice the depth, so one compare and subtract folds it back.
    always_comb begin
        w_sum = SW'(i_front) + SW'(i_count) - ((i_op == OP_POP_BACK) ? SW'(1) : SW'(0));
        if (w_sum >= SW'(LIST_DEPTH)) begin
            w_sum = w_sum - SW'(LIST_DEPTH);
        end
        w_end_slot = w_sum[PW-1:0];
    end

    assign w_front_next = (i_front == PW'(LIST_DEPTH - 1)) ? '0 : i_front + PW'(1);
    assign w_ring_next  = (r_ring == PW'(LIST_DEPTH - 1)) ? '0 : r_ring + PW'(1);

    // The shared compare unit: one stored entry per cycle against the key.
    assign w_hit   = (i_rdata == {i_tail, i_head});
    assign w_full  = (i_count >= CW'(LIST_DEPTH));
    assign w_empty = (i_count == '0);
    assign w_last  = ((r_k + CW'(1)) == i_count);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_accept) begin
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (i_op)
                    OP_APPEND:    n_state = S_DONE;
                    OP_POP_FRONT: n_state = w_empty ? S_DONE : S_POP;
                    OP_POP_BACK:  n_state = w_empty ? S_DONE : S_POP;
                    OP_SEARCH:    n_state = w_empty ? S_DONE : S_SCAN;
                    default:      n_state = S_DONE;
                endcase
            end
            S_POP: n_state = S_DONE;
            S_SCAN: begin
                if (w_hit || w_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_we     = 1'b0;
        o_re     = 1'b0;
        o_slot   = w_end_slot;
        o_ptr    = '0;
        o_load   = 1'b0;
        n_k      = r_k;
        n_ring   = r_ring;
        n_result = r_result;
        case (r_state)
            S_DISPATCH: begin
                n_result = '{status: ST_OK, found: 1'b0, head: '0, tail: '0};
                case (i_op)
                    OP_APPEND: begin
                        if (w_full) begin
                            n_result.status = ST_FULL;
                        end else begin
                            o_we            = 1'b1;
                            o_ptr.inc_count = 1'b1;
                        end
                    end
                    OP_POP_FRONT, OP_POP_BACK: begin
                        if (w_empty) begin
                            n_result.status = ST_EMPTY;
                        end else begin
                            o_re            = 1'b1;
                            o_slot          = (i_op == OP_POP_FRONT) ? i_front : w_end_slot;
                            o_ptr.inc_front = (i_op == OP_POP_FRONT);
                            o_ptr.dec_count = 1'b1;
                        end
                    end
                    OP_SEARCH: begin
                        o_re   = !w_empty;
                        o_slot = i_front;
                        n_ring = w_front_next;
                        n_k    = '0;
                    end
                    default: ;
                endcase
            end
            S_POP: begin
                n_result.head = i_rdata[NAME_HEAD_W-1:0];
                n_result.tail = i_rdata[NAME_W-1:NAME_HEAD_W];
            end
            S_SCAN: begin
                o_slot = r_ring;
                if (w_hit) begin
                    n_result.found = 1'b1;
                end else if (!w_last) begin
                    o_re   = 1'b1;
                    n_ring = w_ring_next;
                    n_k    = r_k + CW'(1);
                end
            end
            S_DONE: o_load = i_out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k      <= n_k;
        r_ring   <= n_ring;
        r_result <= n_result;
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_result = r_result;

endmodule

// ===== rtl/dual_deque_with_member_search.sv =====
// Append and failed removals go from dispatch straight to the done state; removals pass
// the pop state first, and a membership test scans up to LIST_DEPTH entries, one per
// cycle; the single shared name comparator and the one read port of the name memory set
// the scan rate. No new item is taken during work.
// Reset (synchronous, active low) empties both lists and the output register; the name
// memory is not cleared, since only counted entries are ever read.
module dual_deque_with_member_search import dds_pkg::*; #(
    parameter int LIST_DEPTH = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [1:0]             i_operation,
    input  logic                   i_list_select,
    input  logic [NAME_HEAD_W-1:0] i_name_head,
    input  logic [NAME_TAIL_W-1:0] i_name_tail,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [1:0]             o_status,
    output logic                   o_found,
    output logic [NAME_HEAD_W-1:0] o_removed_head,
    output logic [NAME_TAIL_W-1:0] o_removed_tail
);

`include "dual_deque_with_member_search_assert.svh"

    // Each list owns a ring of 2**PW slots in one shared memory; the list
    // select bit is the top address bit, so no multiply is needed to place it.
    localparam int PW        = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CW        = $clog2(LIST_DEPTH + 1);
    localparam int RAM_DEPTH = 2 * (2 ** PW);

    // The accepted item is held here for the whole operation.
    t_op                     r_op;
    logic                    r_list;
    logic [NAME_HEAD_W-1:0]  r_head;
    logic [NAME_TAIL_W-1:0]  r_tail;

    // Per-list ring state: front slot and number of entries.
    logic [PW-1:0]           r_front [2];
    logic [CW-1:0]           r_count [2];

    // Output register; it frees the sequencer as soon as a result is parked.
    logic                    r_out_valid;
    t_result                 r_out;

    logic                    w_in_xfer;
    logic                    w_busy;
    logic                    w_out_free;
    logic                    w_we;
    logic                    w_re;
    logic [PW-1:0]           w_slot;
    logic [NAME_W-1:0]       w_rdata;
    t_ptr_cmd                w_ptr;
    logic                    w_load;
    t_result                 w_result;
    logic [PW-1:0]           w_front;
    logic [CW-1:0]           w_count;

    assign o_in_stall = w_busy;
    assign w_in_xfer  = i_in_valid && !w_busy;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_front    = r_front[r_list];
    assign w_count    = r_count[r_list];

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_op   <= t_op'(i_operation);
            r_list <= i_list_select;
            r_head <= i_name_head;
            r_tail <= i_name_tail;
        end
    end

    // The sequencer: dispatches the operation, drives the memory and, for a
    // membership test, walks the list through the shared comparator.
    dds_ctrl #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_in_xfer),
        .i_op       (r_op),
        .i_head     (r_head),
        .i_tail     (r_tail),
        .i_front    (w_front),
        .i_count    (w_count),
        .i_out_free (w_out_free),
        .i_rdata    (w_rdata),
        .o_busy     (w_busy),
        .o_we       (w_we),
        .o_re       (w_re),
        .o_slot     (w_slot),
        .o_ptr      (w_ptr),
        .o_load     (w_load),
        .o_result   (w_result)
    );

    // Each entry keeps its own copy of the name: ninth byte above the first eight.
    dds_ram #(
        .WIDTH (NAME_W),
        .DEPTH (RAM_DEPTH)
    ) u_name_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr ({r_list, w_slot}),
        .i_wdata ({r_tail, r_head}),
        .i_re    (w_re),
        .i_raddr ({r_list, w_slot}),
        .o_rdata (w_rdata)
    );

    // Pointer updates apply only to the list the current item selected.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front[0] <= '0;
            r_front[1] <= '0;
            r_count[0] <= '0;
            r_count[1] <= '0;
        end else begin
            if (w_ptr.inc_front) begin
                r_front[r_list] <= (w_front == PW'(LIST_DEPTH - 1)) ? '0 : w_front + PW'(1);
            end
            if (w_ptr.inc_count) begin
                r_count[r_list] <= w_count + CW'(1);
            end else if (w_ptr.dec_count) begin
                r_count[r_list] <= w_count - CW'(1);
            end
        end
    end

    // A parked result leaves on an output transfer; a new one is loaded only
    // when the register is empty or being emptied in the same cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out.status;
    assign o_found        = r_out.found;
    assign o_removed_head = r_out.head;
    assign o_removed_tail = r_out.tail;

    `DDS_ASSERT_SAME(a_count_bound,
        1'b1,
        (r_count[0] <= CW'(LIST_DEPTH)) && (r_count[1] <= CW'(LIST_DEPTH)),
        "list entry count above depth")
    `DDS_ASSERT_SAME(a_load_when_free,
        w_load,
        w_out_free,
        "result loaded over a stalled output")
    `DDS_ASSERT_SAME(a_full_means_full,
        w_load && (w_result.status == ST_FULL),
        (r_op == OP_APPEND) && (w_count == CW'(LIST_DEPTH)),
        "full status without a full list")
    `DDS_ASSERT_NEXT(a_found_from_search,
        w_load && w_result.found,
        o_out_valid && o_found && (r_op == OP_SEARCH),
        "found set outside a membership test")

endmodule
